// ===== src/olen_pkg.sv =====
`timescale 1ns / 1ps
// olen_pkg: shared constants, codes and control/status structs of the
// ordered list engine. No dependencies.
package olen_pkg;

  localparam int Depth  = 16;
  localparam int AddrW  = $clog2(Depth);
  localparam int CountW = 5;
  localparam int DataW  = 32;
  localparam int FuncW  = 2;
  localparam int StatW  = 2;

  typedef enum logic [FuncW-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_READ   = 2'd2,
    FN_SEARCH = 2'd3
  } func_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ADDR_IDX  = 2'd0,
    ADDR_PREV = 2'd1,
    ADDR_NEXT = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    addr_sel_t addr_sel;
    logic      ram_we;
    logic      wr_val;
    logic      idx_inc;
    logic      idx_dec;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cap_read;
    logic      cap_match;
    logic      out_load;
  } olen_cmd_t;

  typedef struct packed {
    func_t func;
    logic  err;
    logic  idx_gt_pos;
    logic  idx_next_lt_count;
    logic  idx_lt_count;
    logic  match;
    logic  out_busy;
  } olen_stat_t;

endpackage

// ===== src/olen_req_if.sv =====
`timescale 1ns / 1ps
// olen_req_if: request channel of the ordered list engine.
// Depends on olen_pkg for field widths.
interface olen_req_if;
  logic                                valid;
  logic                                ready;
  logic [olen_pkg::FuncW-1:0]          func;
  logic [olen_pkg::CountW-1:0]         position;
  logic signed [olen_pkg::DataW-1:0]   item_value;

  modport source (output valid, output func, output position, output item_value,
                  input ready);
  modport sink   (input valid, input func, input position, input item_value,
                  output ready);
endinterface

// ===== src/olen_rsp_if.sv =====
`timescale 1ns / 1ps
// olen_rsp_if: result channel of the ordered list engine.
// Depends on olen_pkg for field widths.
interface olen_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [olen_pkg::DataW-1:0]   read_value;
  logic                                found;
  logic [olen_pkg::CountW-1:0]         entry_count;
  logic [olen_pkg::StatW-1:0]          status;

  modport source (output valid, output read_value, output found, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input read_value, input found, input entry_count,
                  input status, output ready);
endinterface

// ===== src/olen_ram.sv =====
`timescale 1ns / 1ps
// olen_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module olen_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/olen_ctrl.sv =====
`timescale 1ns / 1ps
// olen_ctrl: sequencer of the ordered list engine; walks the shift, read
// and search loops. Depends on olen_pkg.
module olen_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  olen_pkg::olen_stat_t stat,
  output olen_pkg::olen_cmd_t  cmd
);
  import olen_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_LOOP   = 11'b000_0000_0010,
    S_SH_RD  = 11'b000_0000_0100,
    S_SH_WR  = 11'b000_0000_1000,
    S_PUT    = 11'b000_0001_0000,
    S_DROP   = 11'b000_0010_0000,
    S_RD_ISS = 11'b000_0100_0000,
    S_RD_CAP = 11'b000_1000_0000,
    S_SC_ISS = 11'b001_0000_0000,
    S_SC_CMP = 11'b010_0000_0000,
    S_RESP   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_IDX;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat.err) begin
          state_nxt = S_RESP;
        end else begin
          case (stat.func)
            FN_INSERT: state_nxt = stat.idx_gt_pos ? S_SH_RD : S_PUT;
            FN_REMOVE: state_nxt = stat.idx_next_lt_count ? S_SH_RD : S_DROP;
            FN_READ:   state_nxt = S_RD_ISS;
            default:   state_nxt = stat.idx_lt_count ? S_SC_ISS : S_RESP;
          endcase
        end
      end
      S_SH_RD: begin
        cmd.addr_sel = (stat.func == FN_INSERT) ? ADDR_PREV : ADDR_NEXT;
        state_nxt    = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.ram_we = 1'b1;
        if (stat.func == FN_INSERT) begin
          cmd.idx_dec = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
        state_nxt = S_LOOP;
      end
      S_PUT: begin
        cmd.ram_we  = 1'b1;
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_RESP;
      end
      S_DROP: begin
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RD_ISS: begin
        state_nxt = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.cap_read = 1'b1;
        state_nxt    = S_RESP;
      end
      S_SC_ISS: begin
        state_nxt = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (stat.match) begin
          cmd.cap_match = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_LOOP;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/olen_dp.sv =====
`timescale 1ns / 1ps
// olen_dp: datapath of the ordered list engine: entry RAM, count, walk
// index, request and result registers. Depends on olen_pkg, olen_ram.
module olen_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [olen_pkg::FuncW-1:0]        in_func,
  input  logic [olen_pkg::CountW-1:0]       in_position,
  input  logic signed [olen_pkg::DataW-1:0] in_item_value,
  input  olen_pkg::olen_cmd_t               cmd,
  output olen_pkg::olen_stat_t              stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [olen_pkg::DataW-1:0] out_read_value,
  output logic                              out_found,
  output logic [olen_pkg::CountW-1:0]       out_entry_count,
  output logic [olen_pkg::StatW-1:0]        out_status
);
  import olen_pkg::*;

  func_t                    func_r;
  logic [CountW-1:0]        pos_r;
  logic [DataW-1:0]         val_r;
  logic [CountW-1:0]        idx_r, idx_nxt;
  logic [CountW-1:0]        count_r, count_nxt;
  status_t                  status_r, st_in;
  logic                     found_r;
  logic [DataW-1:0]         rdval_r;
  logic                     out_valid_r;
  logic [DataW-1:0]         out_read_value_r;
  logic                     out_found_r;
  logic [CountW-1:0]        out_count_r;
  status_t                  out_status_r;

  logic [CountW-1:0]        idx_prev, idx_next;
  logic [AddrW-1:0]         raddr;
  logic [DataW-1:0]         rdata, wdata;
  func_t                    func_in;

  assign func_in  = func_t'(in_func);
  assign idx_prev = idx_r - CountW'(1);
  assign idx_next = idx_r + CountW'(1);

  always_comb begin
    st_in = ST_OK;
    case (func_in)
      FN_INSERT: begin
        if (in_position > count_r) begin
          st_in = ST_RANGE;
        end else if (count_r >= CountW'(Depth)) begin
          st_in = ST_FULL;
        end
      end
      FN_REMOVE, FN_READ: begin
        if (count_r == '0) begin
          st_in = ST_EMPTY;
        end else if (in_position >= count_r) begin
          st_in = ST_RANGE;
        end
      end
      default: st_in = ST_OK;
    endcase
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_PREV: raddr = idx_prev[AddrW-1:0];
      ADDR_NEXT: raddr = idx_next[AddrW-1:0];
      default:   raddr = idx_r[AddrW-1:0];
    endcase
  end

  assign wdata = cmd.wr_val ? val_r : rdata;

  olen_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (idx_r[AddrW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      case (func_in)
        FN_INSERT: idx_nxt = count_r;
        FN_SEARCH: idx_nxt = '0;
        default:   idx_nxt = in_position;
      endcase
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_next;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_prev;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CountW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      func_r   <= func_in;
      pos_r    <= in_position;
      val_r    <= in_item_value;
      status_r <= st_in;
      found_r  <= 1'b0;
      rdval_r  <= '0;
    end
    if (cmd.cap_read) begin
      rdval_r <= rdata;
    end
    if (cmd.cap_match) begin
      found_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_read_value_r <= rdval_r;
      out_found_r      <= found_r;
      out_count_r      <= count_r;
      out_status_r     <= status_r;
    end
  end

  assign stat.func              = func_r;
  assign stat.err               = (status_r != ST_OK);
  assign stat.idx_gt_pos        = (idx_r > pos_r);
  assign stat.idx_next_lt_count = ({1'b0, idx_r} + (CountW + 1)'(1)) < {1'b0, count_r};
  assign stat.idx_lt_count      = (idx_r < count_r);
  assign stat.match             = (rdata == val_r);
  assign stat.out_busy          = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(Depth))
    else $error("entry count above depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ram_we |-> (idx_r < CountW'(Depth)))
    else $error("RAM write index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("result overwrites a pending item");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |=> (count_r == $past(count_r) + CountW'(1)))
    else $error("count did not advance on insert");
`endif

endmodule

// ===== src/ordered_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Ordered list engine: list of up to Depth signed 32-bit entries with
// insert, remove, read and search requests; one result item per request.
// Request channel in_req (func, position, item_value) and result channel
// out_rsp (read_value, found, entry_count, status), both valid/ready; an
// item moves on a rising edge with valid and ready high.
// Entries live in a single-port-read RAM; a sequencer walks it one entry at
// a time, so a request is accepted only while the engine is idle.
// Work from accept to out_rsp.valid, per request:
//   insert: shift up by one (count - position) entries, then write the new one
//   remove: shift down by one (count - position - 1) entries, then drop one
//   read:   one RAM read, captured into the result
//   search: compare entries from index 0 on, up to and including the first
//           match, or through every entry on a miss
//   rejected request: straight to the result
// The next request is taken in the cycle after the result is loaded. Each
// shifted entry takes a RAM read followed by a RAM write.
// The result sits in an output register: the engine may accept and work on
// the next request while out_rsp is stalled, and holds it finished until
// the register frees. Reset empties the list (count zero) and drops any
// pending result; entry contents need no clearing.
module ordered_list_engine_unit (
  input  logic       clk,
  input  logic       rst_n,
  olen_req_if.sink   in_req,
  olen_rsp_if.source out_rsp
);
  import olen_pkg::*;

  olen_cmd_t  cmd;
  olen_stat_t stat;

  olen_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  olen_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_req.func),
    .in_position     (in_req.position),
    .in_item_value   (in_req.item_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_rsp.ready),
    .out_valid       (out_rsp.valid),
    .out_read_value  (out_rsp.read_value),
    .out_found       (out_rsp.found),
    .out_entry_count (out_rsp.entry_count),
    .out_status      (out_rsp.status)
  );

endmodule

// ===== tb/sv/list_result_checker.sv =====
`timescale 1ns / 1ps
// list_result_checker: watches the request and result channels of the ordered
// list engine, keeps its own copy of the list and checks every result item.
// Depends on olen_pkg for widths, function and status codes.
module list_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [olen_pkg::FuncW-1:0]        in_func,
  input  logic [olen_pkg::CountW-1:0]       in_position,
  input  logic signed [olen_pkg::DataW-1:0] in_item_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [olen_pkg::DataW-1:0] out_read_value,
  input  logic                              out_found,
  input  logic [olen_pkg::CountW-1:0]       out_entry_count,
  input  logic [olen_pkg::StatW-1:0]        out_status,
  output int                                fail_count,
  output int                                pending,
  output int                                results_checked,
  output int                                full_hits,
  output int                                range_hits,
  output int                                empty_hits,
  output int                                search_hits
);
  import olen_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic                    found;
    logic [CountW-1:0]       entry_count;
    status_t                 status;
  } list_result_t;

  logic signed [DataW-1:0] list_mem [Depth];
  logic [CountW-1:0]       list_len;
  list_result_t            rsp_q [$];
  list_result_t            got;
  list_result_t            want;
  int                      fails;
  int                      n_checked;
  int                      n_full;
  int                      n_range;
  int                      n_empty;
  int                      n_hit;

  initial begin
    fails     = 0;
    n_checked = 0;
    n_full    = 0;
    n_range   = 0;
    n_empty   = 0;
    n_hit     = 0;
    list_len  = '0;
  end

  function automatic list_result_t apply_request(input func_t f,
                                                 input logic [CountW-1:0] p,
                                                 input logic signed [DataW-1:0] v);
    list_result_t r;
    int i;
    r = '0;
    r.status = ST_OK;
    case (f)
      FN_INSERT: begin
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= Depth) begin
          r.status = ST_FULL;
        end else begin
          for (i = int'(list_len); i > int'(p); i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = v;
          list_len = list_len + 1'b1;
        end
      end
      FN_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(p); i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
          list_len = list_len - 1'b1;
        end
      end
      FN_READ: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_mem[p];
        end
      end
      default: begin
        for (i = 0; i < int'(list_len); i++) begin
          if (list_mem[i] == v) r.found = 1'b1;
        end
      end
    endcase
    r.entry_count = list_len;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = '0;
      rsp_q.delete();
    end else begin
      if (in_valid && in_ready)
        rsp_q.push_back(apply_request(func_t'(in_func), in_position, in_item_value));
      if (out_valid && out_ready) begin
        got.read_value  = out_read_value;
        got.found       = out_found;
        got.entry_count = out_entry_count;
        got.status      = status_t'(out_status);
        if (rsp_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result item value=%0d found=%0b count=%0d status=%0d",
                     $realtime, got.read_value, got.found, got.entry_count, got.status);
        end else begin
          want = rsp_q.pop_front();
          n_checked++;
          case (want.status)
            ST_FULL:  n_full++;
            ST_RANGE: n_range++;
            ST_EMPTY: n_empty++;
            default:  if (want.found) n_hit++;
          endcase
          if (got.read_value !== want.read_value || got.found !== want.found ||
              got.entry_count !== want.entry_count || got.status !== want.status) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch expected value=%0d found=%0b count=%0d status=%s",
                       $realtime, want.read_value, want.found, want.entry_count,
                       want.status.name());
              $display("%0t:          got value=%0d found=%0b count=%0d status=%0d",
                       $realtime, got.read_value, got.found, got.entry_count,
                       got.status);
            end
          end
        end
      end
    end
    fail_count      <= fails;
    pending         <= rsp_q.size();
    results_checked <= n_checked;
    full_hits       <= n_full;
    range_hits      <= n_range;
    empty_hits      <= n_empty;
    search_hits     <= n_hit;
  end

endmodule

// ===== tb/sv/tb_ordered_list_engine_unit.sv =====
`timescale 1ns / 1ps
// tb_ordered_list_engine_unit: drives directed and random list requests into
// the engine under four handshake pressure phases and reports the verdict.
// Depends on olen_pkg, olen_req_if, olen_rsp_if and list_result_checker.
module tb_ordered_list_engine_unit;
  import olen_pkg::*;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} mix_mode_t;

  logic clk;
  logic rst_n;

  olen_req_if req_ch ();
  olen_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int results_checked;
  int full_hits;
  int range_hits;
  int empty_hits;
  int search_hits;

  int        idle_pct;
  int        stall_pct;
  int        shadow_len;
  int        sent;
  int        n;
  int        pick;
  int        ins_w;
  int        rem_w;
  int        rd_w;
  mix_mode_t mode;
  func_t     f;
  logic [CountW-1:0]       p;
  logic signed [DataW-1:0] v;

  ordered_list_engine_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  list_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req_ch.valid),
    .in_ready        (req_ch.ready),
    .in_func         (req_ch.func),
    .in_position     (req_ch.position),
    .in_item_value   (req_ch.item_value),
    .out_valid       (rsp_ch.valid),
    .out_ready       (rsp_ch.ready),
    .out_read_value  (rsp_ch.read_value),
    .out_found       (rsp_ch.found),
    .out_entry_count (rsp_ch.entry_count),
    .out_status      (rsp_ch.status),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .full_hits       (full_hits),
    .range_hits      (range_hits),
    .empty_hits      (empty_hits),
    .search_hits     (search_hits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic signed [DataW-1:0] pool_value();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      4:       return 32'sd1;
      5:       return 32'sh5555_5555;
      6:       return 32'shaaaa_aaaa;
      default: return 32'sd7;
    endcase
  endfunction

  task automatic send_item(input func_t fn, input logic [CountW-1:0] pos,
                           input logic signed [DataW-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= fn;
    req_ch.position   <= pos;
    req_ch.item_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    case (fn)
      FN_INSERT: if (int'(pos) <= shadow_len && shadow_len < Depth) shadow_len++;
      FN_REMOVE: if (shadow_len > 0 && int'(pos) < shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  initial begin
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.func       = FN_INSERT;
    req_ch.position   = '0;
    req_ch.item_value = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    shadow_len        = 0;
    sent              = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, range edges, front/middle/append inserts, removes at both ends
    send_item(FN_READ,   5'd0,  32'sd0);
    send_item(FN_REMOVE, 5'd0,  32'sd0);
    send_item(FN_SEARCH, 5'd0,  32'sd0);
    send_item(FN_INSERT, 5'd1,  32'sd99);
    send_item(FN_INSERT, 5'd0,  32'sh8000_0000);
    send_item(FN_INSERT, 5'd1,  32'sh7fff_ffff);
    send_item(FN_INSERT, 5'd0,  32'sd0);
    send_item(FN_INSERT, 5'd2,  -32'sd1);
    send_item(FN_READ,   5'd0,  32'sd0);
    send_item(FN_READ,   5'd3,  32'sd0);
    send_item(FN_READ,   5'd4,  32'sd0);
    send_item(FN_REMOVE, 5'd4,  32'sd0);
    send_item(FN_SEARCH, 5'd31, 32'sh7fff_ffff);
    send_item(FN_SEARCH, 5'd0,  32'sh1234_5678);
    send_item(FN_REMOVE, 5'd3,  32'sd0);
    send_item(FN_REMOVE, 5'd0,  32'sd0);
    send_item(FN_READ,   5'd16, 32'sd0);
    send_item(FN_INSERT, 5'd16, -32'sd1);
    send_item(FN_SEARCH, 5'd16, 32'sh8000_0000);

    for (n = 0; n < 1750; n++) begin
      if (n % 438 == 0) begin
        case (n / 438)
          0:       begin idle_pct = 0;  stall_pct = 0;  end
          1:       begin idle_pct = 69; stall_pct = 0;  end
          2:       begin idle_pct = 0;  stall_pct = 69; end
          default: begin idle_pct = 26; stall_pct = 26; end
        endcase
      end
      if (n % 40 == 0) mode = (n == 0) ? MODE_GROW : mix_mode_t'($urandom_range(2));
      case (mode)
        MODE_GROW:   begin ins_w = 60; rem_w = 10; rd_w = 15; end
        MODE_SHRINK: begin ins_w = 10; rem_w = 60; rd_w = 15; end
        default:     begin ins_w = 25; rem_w = 25; rd_w = 25; end
      endcase
      pick = $urandom_range(99);
      if (pick < ins_w)                     f = FN_INSERT;
      else if (pick < ins_w + rem_w)        f = FN_REMOVE;
      else if (pick < ins_w + rem_w + rd_w) f = FN_READ;
      else                                  f = FN_SEARCH;

      // mostly legal positions for the current length, some noise over 0..16
      if ($urandom_range(99) < 15) begin
        p = CountW'($urandom_range(16));
      end else if (f == FN_INSERT) begin
        p = CountW'($urandom_range(shadow_len));
      end else if (shadow_len > 0) begin
        p = CountW'($urandom_range(shadow_len - 1));
      end else begin
        p = '0;
      end

      if ($urandom_range(99) < ((f == FN_SEARCH) ? 60 : 30)) v = pool_value();
      else v = $urandom;
      send_item(f, p, v);
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d requests, checked %0d results over four idle/stall phases;",
             sent, results_checked);
    $display("rejects: %0d full, %0d range, %0d empty; %0d search hits.",
             full_hits, range_hits, empty_hits, search_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
